@@ rtl/core/travel_time_solver_unit_defines.svh @@
// ----------------------------------------------------------------------------
// travel_time_solver_unit_defines: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TRAVEL_TIME_SOLVER_UNIT_DEFINES_SVH
`define TRAVEL_TIME_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication
`define TTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tts_pkg.sv @@
// ----------------------------------------------------------------------------
// tts_pkg
// Widths and sideband types shared by the travel time solver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tts_pkg;

  localparam int DW   = 48;            // data width
  localparam int FB   = 16;            // fraction bits
  localparam int HW   = (DW + 1) / 2;  // half operand width for partial products
  localparam int RW   = 2 * DW;        // radicand width
  localparam int SRW  = DW + 2;        // square root remainder width
  localparam int DENW = DW + 1;        // divisor width
  localparam int NW   = DW + FB + 1;   // dividend width
  localparam int RDW  = DW + 2;        // division remainder width

  localparam logic [DW-1:0] T_MAX = '1;

  // item data carried alongside the square root chain
  typedef struct packed {
    logic [DW-1:0] dlen;
    logic [DW-1:0] speed;
    logic          azero;
    logic          zero;
    logic          inf;
  } tts_sqrt_side_t;

  // item flags carried alongside the division chain
  typedef struct packed {
    logic zero;
    logic inf;
    logic sat;
  } tts_div_side_t;

  // one finished result
  typedef struct packed {
    logic [DW-1:0] ttime;
    logic          inf;
    logic          sat;
  } tts_res_t;

endpackage

@@ rtl/core/tts_front.sv @@
// ----------------------------------------------------------------------------
// tts_front
// Classifies the item and forms v*v + 2*a*d over two stages of partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tts_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [tts_pkg::DW-1:0]     distance_i,
  input  logic [tts_pkg::DW-1:0]     speed_i,
  input  logic [tts_pkg::DW-1:0]     accel_i,
  output logic                       valid_o,
  output logic [tts_pkg::RW-1:0]     rad_o,
  output tts_pkg::tts_sqrt_side_t    side_o
);
  import tts_pkg::*;

  logic [2*HW-1:0] vx, ax, dx;
  logic [2*HW-1:0] vv_d [4];
  logic [2*HW-1:0] ad_d [4];
  logic [2*HW-1:0] vv_q [4];
  logic [2*HW-1:0] ad_q [4];
  tts_sqrt_side_t  side_d, side1_q;
  logic            valid1_q;
  logic [4*HW-1:0] vv_sum, ad_sum;

  // classification and half-width partial products
  always_comb begin
    vx = (2*HW)'(speed_i);
    ax = (2*HW)'(accel_i);
    dx = (2*HW)'(distance_i);
    vv_d[0] = vx[HW-1:0]    * vx[HW-1:0];
    vv_d[1] = vx[HW-1:0]    * vx[2*HW-1:HW];
    vv_d[2] = vx[2*HW-1:HW] * vx[HW-1:0];
    vv_d[3] = vx[2*HW-1:HW] * vx[2*HW-1:HW];
    ad_d[0] = ax[HW-1:0]    * dx[HW-1:0];
    ad_d[1] = ax[HW-1:0]    * dx[2*HW-1:HW];
    ad_d[2] = ax[2*HW-1:HW] * dx[HW-1:0];
    ad_d[3] = ax[2*HW-1:HW] * dx[2*HW-1:HW];
    side_d.dlen  = distance_i;
    side_d.speed = speed_i;
    side_d.azero = (accel_i == '0);
    side_d.zero  = (distance_i == '0) | distance_i[DW-1];
    side_d.inf   = (speed_i == '0) | speed_i[DW-1] | accel_i[DW-1];
  end

  // partial product sums
  always_comb begin
    vv_sum = (4*HW)'(vv_q[0]) + ((4*HW)'(vv_q[1]) << HW) + ((4*HW)'(vv_q[2]) << HW)
           + ((4*HW)'(vv_q[3]) << (2*HW));
    ad_sum = (4*HW)'(ad_q[0]) + ((4*HW)'(ad_q[1]) << HW) + ((4*HW)'(ad_q[2]) << HW)
           + ((4*HW)'(ad_q[3]) << (2*HW));
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid_o  <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid_o  <= valid1_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vv_q    <= vv_d;
      ad_q    <= ad_d;
      side1_q <= side_d;
      rad_o   <= RW'(vv_sum + (ad_sum << 1));
      side_o  <= side1_q;
    end
  end

endmodule

@@ rtl/core/tts_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// tts_sqrt_cell
// One digit of the integer square root: brings down two radicand bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tts_sqrt_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [tts_pkg::RW-1:0]   rad_i,
  input  logic [tts_pkg::DW-1:0]   root_i,
  input  logic [tts_pkg::SRW-1:0]  rem_i,
  input  tts_pkg::tts_sqrt_side_t  side_i,
  output logic                     valid_o,
  output logic [tts_pkg::RW-1:0]   rad_o,
  output logic [tts_pkg::DW-1:0]   root_o,
  output logic [tts_pkg::SRW-1:0]  rem_o,
  output tts_pkg::tts_sqrt_side_t  side_o
);
  import tts_pkg::*;

  logic [SRW-1:0] rs, trial;
  logic           ge;

  // trial subtraction of 4*root + 1
  always_comb begin
    rs    = {rem_i[SRW-3:0], rad_i[RW-1 -: 2]};
    trial = {root_i, 2'b01};
    ge    = (rs >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= rad_i << 2;
      root_o <= {root_i[DW-2:0], ge};
      rem_o  <= ge ? (rs - trial) : rs;
      side_o <= side_i;
    end
  end

endmodule

@@ rtl/core/tts_div_cell.sv @@
// ----------------------------------------------------------------------------
// tts_div_cell
// One quotient bit of restoring division: shift in a dividend bit, compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tts_div_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [tts_pkg::DW-1:0]   num_i,
  input  logic [tts_pkg::DENW-1:0] den_i,
  input  logic [tts_pkg::DW-1:0]   quo_i,
  input  logic [tts_pkg::RDW-1:0]  rem_i,
  input  tts_pkg::tts_div_side_t   side_i,
  output logic                     valid_o,
  output logic [tts_pkg::DW-1:0]   num_o,
  output logic [tts_pkg::DENW-1:0] den_o,
  output logic [tts_pkg::DW-1:0]   quo_o,
  output logic [tts_pkg::RDW-1:0]  rem_o,
  output tts_pkg::tts_div_side_t   side_o
);
  import tts_pkg::*;

  logic [RDW-1:0] rs, dx;
  logic           ge;

  // compare shifted remainder against divisor
  always_comb begin
    rs = {rem_i[RDW-2:0], num_i[DW-1]};
    dx = RDW'(den_i);
    ge = (rs >= dx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= num_i << 1;
      den_o  <= den_i;
      quo_o  <= {quo_i[DW-2:0], ge};
      rem_o  <= ge ? (rs - dx) : rs;
      side_o <= side_i;
    end
  end

endmodule

@@ rtl/core/travel_time_solver_unit.sv @@
// ----------------------------------------------------------------------------
// travel_time_solver_unit
// Time to cover a distance from a speed under constant acceleration.
// ----------------------------------------------------------------------------
// The unit takes one transaction per cycle and returns one result per
// transaction, in order, through two stages of partial products, a chain of DW
// square root cells (one root bit each), one stage that forms divisor and
// dividend, and a chain of DW division cells (one quotient bit each). A
// two-entry output buffer sits at the end, so input keeps flowing while one
// result waits; the pipeline holds only when both buffer entries are taken.
`timescale 1ns / 1ps
`include "travel_time_solver_unit_defines.svh"
module travel_time_solver_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [tts_pkg::DW-1:0]   distance_i,
  input  logic [tts_pkg::DW-1:0]   initial_speed_i,
  input  logic [tts_pkg::DW-1:0]   accel_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [tts_pkg::DW-1:0]   travel_time_o,
  output logic                     is_infinite_o,
  output logic                     saturated_o
);
  import tts_pkg::*;

  logic en;

  // square root chain
  logic           sq_valid [DW+1];
  logic [RW-1:0]  sq_rad   [DW+1];
  logic [DW-1:0]  sq_root  [DW+1];
  logic [SRW-1:0] sq_rem   [DW+1];
  tts_sqrt_side_t sq_side  [DW+1];

  // division chain
  logic            dv_valid [DW+1];
  logic [DW-1:0]   dv_num   [DW+1];
  logic [DENW-1:0] dv_den   [DW+1];
  logic [DW-1:0]   dv_quo   [DW+1];
  logic [RDW-1:0]  dv_rem   [DW+1];
  tts_div_side_t   dv_side  [DW+1];

  // divisor and dividend forming
  tts_sqrt_side_t  ps;
  logic [DENW-1:0] den_d;
  logic [NW-1:0]   num_d;
  logic [FB:0]     num_hi;
  tts_div_side_t   dside_d;

  // output buffer
  tts_res_t    res_d;
  tts_res_t    buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  tts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .distance_i (distance_i),
    .speed_i    (initial_speed_i),
    .accel_i    (accel_i),
    .valid_o    (sq_valid[0]),
    .rad_o      (sq_rad[0]),
    .side_o     (sq_side[0])
  );

  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  for (genvar k = 0; k < DW; k++) begin : g_sqrt
    tts_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[k]),
      .rad_i   (sq_rad[k]),
      .root_i  (sq_root[k]),
      .rem_i   (sq_rem[k]),
      .side_i  (sq_side[k]),
      .valid_o (sq_valid[k+1]),
      .rad_o   (sq_rad[k+1]),
      .root_o  (sq_root[k+1]),
      .rem_o   (sq_rem[k+1]),
      .side_o  (sq_side[k+1])
    );
  end

  // divisor root + v (or v alone), dividend 2d or d scaled by the fraction
  always_comb begin
    ps    = sq_side[DW];
    den_d = ps.azero ? DENW'(ps.speed) : (DENW'(sq_root[DW]) + DENW'(ps.speed));
    num_d = ps.azero ? (NW'(ps.dlen) << FB) : (NW'(ps.dlen) << (FB + 1));
    num_hi       = num_d[NW-1:DW];
    dside_d.zero = ps.zero;
    dside_d.inf  = ps.inf;
    dside_d.sat  = (NW'(num_hi) >= NW'(den_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= sq_valid[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_num[0]  <= num_d[DW-1:0];
      dv_den[0]  <= den_d;
      dv_quo[0]  <= '0;
      dv_rem[0]  <= RDW'(num_hi);
      dv_side[0] <= dside_d;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    tts_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[k]),
      .num_i   (dv_num[k]),
      .den_i   (dv_den[k]),
      .quo_i   (dv_quo[k]),
      .rem_i   (dv_rem[k]),
      .side_i  (dv_side[k]),
      .valid_o (dv_valid[k+1]),
      .num_o   (dv_num[k+1]),
      .den_o   (dv_den[k+1]),
      .quo_o   (dv_quo[k+1]),
      .rem_o   (dv_rem[k+1]),
      .side_o  (dv_side[k+1])
    );
  end

  // final result selection
  always_comb begin
    res_d.ttime = dv_quo[DW];
    res_d.inf   = 1'b0;
    res_d.sat   = 1'b0;
    if (dv_side[DW].zero) begin
      res_d.ttime = '0;
    end else if (dv_side[DW].inf) begin
      res_d.ttime = T_MAX;
      res_d.inf   = 1'b1;
    end else if (dv_side[DW].sat) begin
      res_d.ttime = T_MAX;
      res_d.sat   = 1'b1;
    end
  end

  assign push = en && dv_valid[DW];
  assign pop  = out_valid_o && out_ready_i;

  // output buffer pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res_d;
    end
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign travel_time_o = buf_q[rd_ptr_q].ttime;
  assign is_infinite_o = buf_q[rd_ptr_q].inf;
  assign saturated_o   = buf_q[rd_ptr_q].sat;

  // checks
  `TTS_ASSERT_IMPL(a_flags_excl, out_valid_o, !(is_infinite_o && saturated_o), "both flags set")
  `TTS_ASSERT_IMPL(a_flag_max, out_valid_o && (is_infinite_o || saturated_o), travel_time_o == T_MAX, "flagged time not max")
  `TTS_ASSERT_IMPL(a_no_overfill, cnt_q == 2'd2, !push, "push into full buffer")
  `TTS_ASSERT_NEXT(a_fill_hold, cnt_q == 2'd2 && !out_ready_i, cnt_q == 2'd2, "buffer drained without pop")

endmodule
